/* rtl/owm_pkg.sv */
// ----------------------------------------------------------------------------
// One-wire bus master package
// Shared types and constants for the bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned NumCfg = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TimeW = 10;

  localparam logic [CfgIdxW-1:0] CfgResetLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPresWait  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgResetTail = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlotLow   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSampWait  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSlotTail  = 3'd5;

  localparam logic [7:0] CmdSearchRom = 8'hF0;
  localparam logic [7:0] CmdMatchRom  = 8'h55;
  localparam logic [7:0] CmdSkipRom   = 8'hCC;

  typedef enum logic [2:0] {
    KindTick   = 3'd0,
    KindReset  = 3'd1,
    KindByte   = 3'd2,
    KindSearch = 3'd3,
    KindCmd    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OpNone   = 3'd0,
    OpReset  = 3'd1,
    OpByte   = 3'd2,
    OpSearch = 3'd3,
    OpCmd    = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    PhIdle       = 4'd0,
    PhRstLow     = 4'd1,
    PhRstWait    = 4'd2,
    PhRstTail    = 4'd3,
    PhSlotLow    = 4'd4,
    PhSlotSample = 4'd5,
    PhSlotTail   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    SubFirst = 2'd0,
    SubSecond = 2'd1,
    SubWrite = 2'd2,
    SubSendCmd = 2'd3
  } sub_e;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StNoPresence = 2'd1,
    StDataErr = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic        line_level;
    logic [7:0]  data_byte;
    logic [63:0] rom_id;
    logic        use_match;
    logic [6:0]  last_discrepancy;
  } in_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [6:0]  next_discrepancy;
    logic [63:0] found_id;
  } out_t;

  typedef struct packed {
    logic [TimeW-1:0] reset_low;
    logic [TimeW-1:0] pres_wait;
    logic [TimeW-1:0] reset_tail;
    logic [TimeW-1:0] slot_low;
    logic [TimeW-1:0] samp_wait;
    logic [TimeW-1:0] slot_tail;
  } cfg_t;

endpackage

/* rtl/owm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// One-wire bus master timing registers
// Holds the six timing registers written through the configuration port.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]   idx_i,
  input  logic [owm_pkg::TimeW-1:0]     data_i,
  output owm_pkg::cfg_t                 cfg_o
);
  import owm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low  <= TimeW'(480);
      cfg_q.pres_wait  <= TimeW'(66);
      cfg_q.reset_tail <= TimeW'(414);
      cfg_q.slot_low   <= TimeW'(1);
      cfg_q.samp_wait  <= TimeW'(14);
      cfg_q.slot_tail  <= TimeW'(45);
    end else if (we_i) begin
      case (idx_i)
        CfgResetLow:  cfg_q.reset_low  <= data_i;
        CfgPresWait:  cfg_q.pres_wait  <= data_i;
        CfgResetTail: cfg_q.reset_tail <= data_i;
        CfgSlotLow:   cfg_q.slot_low   <= data_i;
        CfgSampWait:  cfg_q.samp_wait  <= data_i;
        CfgSlotTail:  cfg_q.slot_tail  <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/owm_engine.sv */
// ----------------------------------------------------------------------------
// One-wire bus master engine
// Timing state machine: one item per in_fire_i cycle, combinational result.
// ----------------------------------------------------------------------------
module owm_engine #(
  parameter int unsigned ROM_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  owm_pkg::cfg_t cfg_i,
  input  logic          in_fire_i,
  input  owm_pkg::in_t  in_i,
  output owm_pkg::out_t res_d_o
);
  import owm_pkg::*;

  localparam int unsigned TotBits = ROM_BYTES * 8;
  localparam int unsigned KW = (TotBits > 1) ? $clog2(TotBits) : 1;
  localparam int unsigned IdxW = 4;

  phase_e            phase_q, phase_d;
  logic [TimeW-1:0]  timer_q, timer_d;
  logic [6:0]        bitcnt_q, bitcnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [63:0]       id_q, id_d;
  logic [6:0]        din_q, din_d, dout_q, dout_d;
  sub_e              sub_q, sub_d;
  logic              first_q, first_d, slotv_q, slotv_d, samp_q, samp_d;
  logic [IdxW-1:0]   bidx_q, bidx_d;
  logic              match_q, match_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [1:0]        st_q, st_d;
  op_e               op_q, op_d;

  logic [TimeW:0]    t1;
  logic [TimeW-1:0]  lim;
  logic              el, done;
  logic [6:0]        pos;
  logic [KW-1:0]     k;
  logic              bsel;
  logic [IdxW-1:0]   nidx, lastpre;
  logic [7:0]        nsh;
  logic [2:0]        bsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; timer_q <= '0; bitcnt_q <= '0; shift_q <= '0;
      id_q <= '0; din_q <= '0; dout_q <= '0; sub_q <= SubFirst;
      first_q <= 1'b0; slotv_q <= 1'b0; samp_q <= 1'b0; bidx_q <= '0;
      match_q <= 1'b0; cmd_q <= '0; st_q <= '0; op_q <= OpNone;
    end else if (in_fire_i) begin
      phase_q <= phase_d; timer_q <= timer_d; bitcnt_q <= bitcnt_d;
      shift_q <= shift_d; id_q <= id_d; din_q <= din_d; dout_q <= dout_d;
      sub_q <= sub_d; first_q <= first_d; slotv_q <= slotv_d;
      samp_q <= samp_d; bidx_q <= bidx_d; match_q <= match_d;
      cmd_q <= cmd_d; st_q <= st_d; op_q <= op_d;
    end
  end

  always_comb begin
    case (phase_q)
      PhRstLow:     lim = cfg_i.reset_low;
      PhRstWait:    lim = cfg_i.pres_wait;
      PhRstTail:    lim = cfg_i.reset_tail;
      PhSlotLow:    lim = cfg_i.slot_low;
      PhSlotSample: lim = cfg_i.samp_wait;
      PhSlotTail:   lim = cfg_i.slot_tail;
      default:      lim = '0;
    endcase
  end

  assign t1   = {1'b0, timer_q} + 1'b1;
  assign el   = t1 >= {1'b0, lim};
  assign pos  = bitcnt_q;
  assign k    = KW'(7'(TotBits) - pos);
  assign nsh  = {samp_q, shift_q[7:1]};
  assign nidx = bidx_q + 1'b1;
  assign lastpre = match_q ? IdxW'(ROM_BYTES + 1) : IdxW'(1);
  assign bsh  = 3'(nidx - 1'b1);

  always_comb begin
    phase_d = phase_q; timer_d = timer_q; bitcnt_d = bitcnt_q;
    shift_d = shift_q; id_d = id_q; din_d = din_q; dout_d = dout_q;
    sub_d = sub_q; first_d = first_q; slotv_d = slotv_q; samp_d = samp_q;
    bidx_d = bidx_q; match_d = match_q; cmd_d = cmd_q; st_d = st_q;
    op_d = op_q; done = 1'b0; bsel = first_q;

    if (in_i.kind == KindTick) begin
      if (phase_q != PhIdle) begin
        timer_d = el ? '0 : t1[TimeW-1:0];
      end
      if (phase_q != PhIdle && el) begin
        case (phase_q)
          PhRstLow:  phase_d = PhRstWait;
          PhRstWait: begin
            st_d = in_i.line_level ? StNoPresence : StOk;
            phase_d = PhRstTail;
          end
          PhRstTail: begin
            if (!in_i.line_level) st_d = StNoPresence;
            if (op_q == OpSearch) begin
              if (st_d != StOk) begin
                phase_d = PhIdle; st_d = StNoPresence; done = 1'b1;
              end else begin
                sub_d = SubSendCmd; shift_d = CmdSearchRom; bitcnt_d = 7'd8;
                slotv_d = CmdSearchRom[0]; phase_d = PhSlotLow;
              end
            end else if (op_q == OpCmd) begin
              bidx_d = '0; bitcnt_d = 7'd8;
              shift_d = match_q ? CmdMatchRom : CmdSkipRom;
              slotv_d = shift_d[0]; phase_d = PhSlotLow;
            end else begin
              phase_d = PhIdle; done = 1'b1;
            end
          end
          PhSlotLow: phase_d = PhSlotSample;
          PhSlotSample: begin
            samp_d = slotv_q & in_i.line_level;
            phase_d = PhSlotTail;
          end
          PhSlotTail: begin
            if (op_q != OpSearch || sub_q == SubSendCmd) begin
              shift_d = nsh; bitcnt_d = bitcnt_q - 1'b1;
              if (bitcnt_d != '0) begin
                slotv_d = nsh[0]; phase_d = PhSlotLow;
              end else if (op_q == OpSearch) begin
                sub_d = SubFirst; bitcnt_d = 7'(TotBits);
                slotv_d = 1'b1; phase_d = PhSlotLow;
              end else if (op_q == OpCmd) begin
                bidx_d = nidx;
                if (nidx < lastpre) begin
                  shift_d = id_q[{bsh, 3'b000} +: 8];
                  bitcnt_d = 7'd8; slotv_d = shift_d[0]; phase_d = PhSlotLow;
                end else if (nidx == lastpre) begin
                  shift_d = cmd_q; bitcnt_d = 7'd8;
                  slotv_d = cmd_q[0]; phase_d = PhSlotLow;
                end else begin
                  phase_d = PhIdle; done = 1'b1;
                end
              end else begin
                phase_d = PhIdle; st_d = StOk; done = 1'b1;
              end
            end else if (sub_q == SubFirst) begin
              first_d = samp_q; sub_d = SubSecond;
              slotv_d = 1'b1; phase_d = PhSlotLow;
            end else if (sub_q == SubSecond) begin
              if (first_q && samp_q) begin
                phase_d = PhIdle; st_d = StDataErr; done = 1'b1;
              end else begin
                if (!first_q && !samp_q &&
                    (din_q > pos || (id_q[k] && din_q != pos))) begin
                  bsel = 1'b1; dout_d = pos;
                end
                id_d[k] = bsel;
                sub_d = SubWrite; slotv_d = bsel; phase_d = PhSlotLow;
              end
            end else begin
              bitcnt_d = bitcnt_q - 1'b1;
              if (bitcnt_d == '0) begin
                phase_d = PhIdle; st_d = StOk; done = 1'b1;
              end else begin
                sub_d = SubFirst; slotv_d = 1'b1; phase_d = PhSlotLow;
              end
            end
          end
          default: ;
        endcase
      end
    end else if (phase_q == PhIdle && in_i.kind <= KindCmd) begin
      op_d = op_e'(in_i.kind); st_d = StOk; timer_d = '0;
      case (in_i.kind)
        KindByte: begin
          shift_d = in_i.data_byte; bitcnt_d = 7'd8;
          slotv_d = in_i.data_byte[0]; phase_d = PhSlotLow;
        end
        KindSearch: begin
          din_d = in_i.last_discrepancy; dout_d = '0;
          id_d = in_i.rom_id; phase_d = PhRstLow;
        end
        KindCmd: begin
          match_d = in_i.use_match; cmd_d = in_i.data_byte;
          id_d = in_i.rom_id; phase_d = PhRstLow;
        end
        default: phase_d = PhRstLow;
      endcase
    end

    if (done) timer_d = '0;

    res_d_o = '0;
    case (phase_d)
      PhRstLow, PhSlotLow:       res_d_o.drive_low = 1'b1;
      PhSlotSample, PhSlotTail:  res_d_o.drive_low = !slotv_d;
      default:                   res_d_o.drive_low = 1'b0;
    endcase
    res_d_o.busy_res = phase_d != PhIdle;
    res_d_o.done_res = done;
    if (done) begin
      res_d_o.status = st_d;
      if (op_d == OpByte) res_d_o.read_byte = shift_d;
      if (op_d == OpSearch) begin
        res_d_o.found_id = id_d;
        if (st_d == StOk) res_d_o.next_discrepancy = dout_d;
      end
    end
  end

endmodule

/* rtl/one_wire_bus_master_top.sv */
// ----------------------------------------------------------------------------
// One-wire bus master top level
// Handshake ports, timing registers, engine and result register.
// ----------------------------------------------------------------------------
// Each input transaction (a microsecond tick or a start request) is taken on
// its input handshake and yields one result transaction through an output
// register, so the block sustains one item per cycle while out_ready_i does
// not stall the result register. A new item is accepted while the result
// register is empty or is being drained in the same cycle.
module one_wire_bus_master_top #(
  parameter int unsigned ROM_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  owm_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output owm_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [owm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [owm_pkg::TimeW-1:0]   cfg_data_i
);
  import owm_pkg::*;

  cfg_t cfg;
  out_t res_d, res_q;
  logic valid_q, fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;

  owm_cfg_regs u_cfg (
    .clk_i, .rst_ni,
    .we_i(cfg_valid_i), .idx_i(cfg_index_i), .data_i(cfg_data_i), .cfg_o(cfg)
  );

  owm_engine #(.ROM_BYTES(ROM_BYTES)) u_eng (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_fire_i(fire), .in_i(in_data_i),
    .res_d_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

/* rtl/owm_checker.sv */
// ----------------------------------------------------------------------------
// One-wire bus master checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module owm_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input owm_pkg::out_t out_data_o
);
  import owm_pkg::*;

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done while busy");

  a_idle_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |-> !out_data_o.drive_low)
    else $error("line driven while idle");

endmodule

bind one_wire_bus_master_top owm_checker u_owm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
